### hw/rtl/thermostat_compressor_controller_macros.svh
// ----------------------------------------------------------------------------
// Thermostat compressor controller assertion macros
// Concurrent assertion helpers shared by the controller RTL files.
// ----------------------------------------------------------------------------
`ifndef THERMOSTAT_COMPRESSOR_CONTROLLER_MACROS_SVH
`define THERMOSTAT_COMPRESSOR_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF

`define TCC_ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define TCC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define TCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define TCC_ASSERT_ALWAYS(name, clk, rst, expr)
`define TCC_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define TCC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// Thermostat compressor controller package
// Transfer types, configuration layout, codes and the BCD helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 24;
   localparam int CmpWidth      = 13;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_UP     = 2'd2;
   localparam logic [1:0] CMD_DOWN   = 2'd3;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RUN  = 2'd1;
   localparam logic [1:0] PH_LOCK = 2'd2;

   localparam logic [CsrIndexWidth-1:0] REG_HYSTERESIS      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_MAX_RUN_SAMPLES = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_LOCKOUT_TICKS   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_SETPOINT_MIN    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_SETPOINT_MAX    = 3'd4;

   localparam logic [7:0]  HYSTERESIS_RESET      = 8'd16;
   localparam logic [15:0] MAX_RUN_SAMPLES_RESET = 16'd18000;
   localparam logic [23:0] LOCKOUT_TICKS_RESET   = 24'd1738260;
   localparam logic [6:0]  SETPOINT_MIN_RESET    = 7'd6;
   localparam logic [6:0]  SETPOINT_MAX_RESET    = 7'd25;
   localparam logic [6:0]  SETPOINT_RESET        = 7'd13;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [11:0] sample;
   } req_type;

   typedef struct packed {
      logic       compressor_on;
      logic [1:0] phase;
      logic [3:0] setpoint_tens;
      logic [3:0] setpoint_units;
      logic       run_timed_out;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  hysteresis;
      logic [15:0] max_run_samples;
      logic [23:0] lockout_ticks;
      logic [6:0]  setpoint_min;
      logic [6:0]  setpoint_max;
   } cfg_type;

   // Division by ten through a reciprocal multiply; exact for all 7-bit values.
   function automatic logic [3:0] bcd_tens(input logic [6:0] value);
      logic [14:0] prod;
      prod = {8'b0, value} * 15'd205;
      return prod[14:11];
   endfunction

   function automatic logic [3:0] bcd_units(input logic [6:0] value);
      logic [6:0] tens_x10;
      logic [6:0] diff;
      tens_x10 = {3'b0, bcd_tens(value)} * 7'd10;
      diff = value - tens_x10;
      return diff[3:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/thermostat_compressor_controller.sv
// Input and result registers lie between an input transfer and its result.
// Throughput: one item per cycle unless the output stalls; the state update is a single
// compare and counter step. An item waits in the input register behind a stalled result;
// a waiting result blocks the next input transfer only while the input register is full.
// Reset is synchronous and active high; it loads the configuration reset values,
// sets the setpoint to 13 and the phase to idle, and empties both registers.
// ----------------------------------------------------------------------------
// Thermostat compressor controller
// Hysteresis thermostat with run limit, lockout and BCD setpoint display.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thermostat_compressor_controller_macros.svh"

module thermostat_compressor_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire tcc_pkg::req_type                  req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output tcc_pkg::rsp_type                       rsp_payload,
   input  wire logic                              csr_write_enable,
   input  wire logic [tcc_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [tcc_pkg::CsrDataWidth-1:0]  csr_wdata
);

   tcc_pkg::cfg_type cfg;
   tcc_pkg::req_type in_item_ff;
   tcc_pkg::rsp_type out_item_ff;
   tcc_pkg::rsp_type core_result;
   logic             in_valid_ff;
   logic             in_valid_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   logic             out_free;
   logic             advance;
   logic             accept;

   tcc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   tcc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!in_valid_ff || out_free) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   `TCC_ASSERT_IMPLY(a_drive_matches_phase, clock, reset, rsp_valid, rsp_payload.compressor_on == (rsp_payload.phase == tcc_pkg::PH_RUN))
   `TCC_ASSERT_IMPLY(a_units_digit_range, clock, reset, rsp_valid, rsp_payload.setpoint_units <= 4'd9)
   `TCC_ASSERT_IMPLY(a_stall_only_when_full, clock, reset, req_stall, in_valid_ff && out_valid_ff)

endmodule

`default_nettype wire

### hw/rtl/tcc_csr.sv
// ----------------------------------------------------------------------------
// Thermostat compressor controller configuration registers
// Holds the five control registers written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [tcc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [tcc_pkg::CsrDataWidth-1:0]    csr_wdata,
   output tcc_pkg::cfg_type                         cfg
);

   tcc_pkg::cfg_type cfg_ff;
   tcc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tcc_pkg::REG_HYSTERESIS:      cfg_in.hysteresis      = csr_wdata[7:0];
            tcc_pkg::REG_MAX_RUN_SAMPLES: cfg_in.max_run_samples = csr_wdata[15:0];
            tcc_pkg::REG_LOCKOUT_TICKS:   cfg_in.lockout_ticks   = csr_wdata[23:0];
            tcc_pkg::REG_SETPOINT_MIN:    cfg_in.setpoint_min    = csr_wdata[6:0];
            tcc_pkg::REG_SETPOINT_MAX:    cfg_in.setpoint_max    = csr_wdata[6:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hysteresis      <= tcc_pkg::HYSTERESIS_RESET;
         cfg_ff.max_run_samples <= tcc_pkg::MAX_RUN_SAMPLES_RESET;
         cfg_ff.lockout_ticks   <= tcc_pkg::LOCKOUT_TICKS_RESET;
         cfg_ff.setpoint_min    <= tcc_pkg::SETPOINT_MIN_RESET;
         cfg_ff.setpoint_max    <= tcc_pkg::SETPOINT_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hw/rtl/tcc_core.sv
// ----------------------------------------------------------------------------
// Thermostat compressor controller core
// Setpoint, phase and counter state with the event update applied on each fired item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thermostat_compressor_controller_macros.svh"

module tcc_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire tcc_pkg::req_type      item,
   input  wire tcc_pkg::cfg_type      cfg,
   output tcc_pkg::rsp_type           result
);

   logic [6:0]  setpoint_ff;
   logic [6:0]  setpoint_in;
   logic [1:0]  phase_ff;
   logic [1:0]  phase_in;
   logic [15:0] run_left_ff;
   logic [15:0] run_left_in;
   logic [23:0] lockout_left_ff;
   logic [23:0] lockout_left_in;

   logic signed [tcc_pkg::CmpWidth-1:0] temp;
   logic signed [tcc_pkg::CmpWidth-1:0] sp16;
   logic signed [tcc_pkg::CmpWidth-1:0] hy;
   logic signed [tcc_pkg::CmpWidth-1:0] upper;
   logic signed [tcc_pkg::CmpWidth-1:0] lower;
   logic        timed_out;
   logic        end_run;
   logic        is_run;
   logic        is_lock;

   assign temp  = {item.sample[11], item.sample};
   assign sp16  = {2'b00, setpoint_ff, 4'b0000};
   assign hy    = {5'b00000, cfg.hysteresis};
   assign upper = sp16 + hy;
   assign lower = sp16 - hy;

   assign is_run  = (phase_ff == tcc_pkg::PH_RUN);
   assign is_lock = (phase_ff == tcc_pkg::PH_LOCK);

   always_comb begin
      setpoint_in     = setpoint_ff;
      phase_in        = phase_ff;
      run_left_in     = run_left_ff;
      lockout_left_in = lockout_left_ff;
      timed_out       = 1'b0;
      end_run         = 1'b0;
      unique case (item.command)
         tcc_pkg::CMD_SAMPLE: begin
            if (is_run) begin
               if (run_left_ff <= 16'd1) begin
                  timed_out = 1'b1;
                  end_run   = 1'b1;
               end else begin
                  run_left_in = run_left_ff - 16'd1;
                  end_run     = (temp <= lower);
               end
            end else if (!is_lock) begin
               if (temp > upper) begin
                  phase_in    = tcc_pkg::PH_RUN;
                  run_left_in = cfg.max_run_samples;
               end
            end
         end
         tcc_pkg::CMD_TICK: begin
            if (is_lock) begin
               if (lockout_left_ff <= 24'd1) begin
                  lockout_left_in = '0;
                  phase_in        = tcc_pkg::PH_IDLE;
               end else begin
                  lockout_left_in = lockout_left_ff - 24'd1;
               end
            end
         end
         tcc_pkg::CMD_UP: begin
            if (setpoint_ff < cfg.setpoint_max) begin
               setpoint_in = setpoint_ff + 7'd1;
            end
         end
         tcc_pkg::CMD_DOWN: begin
            if (setpoint_ff > cfg.setpoint_min) begin
               setpoint_in = setpoint_ff - 7'd1;
            end
         end
      endcase
      if (end_run) begin
         run_left_in = '0;
         if (cfg.lockout_ticks == 24'd0) begin
            phase_in        = tcc_pkg::PH_IDLE;
            lockout_left_in = '0;
         end else begin
            phase_in        = tcc_pkg::PH_LOCK;
            lockout_left_in = cfg.lockout_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff     <= tcc_pkg::SETPOINT_RESET;
         phase_ff        <= tcc_pkg::PH_IDLE;
         run_left_ff     <= '0;
         lockout_left_ff <= '0;
      end else if (fire) begin
         setpoint_ff     <= setpoint_in;
         phase_ff        <= phase_in;
         run_left_ff     <= run_left_in;
         lockout_left_ff <= lockout_left_in;
      end
   end

   always_comb begin
      result.compressor_on  = (phase_in == tcc_pkg::PH_RUN);
      result.phase          = (phase_in == tcc_pkg::PH_RUN || phase_in == tcc_pkg::PH_LOCK) ?
                              phase_in : tcc_pkg::PH_IDLE;
      result.setpoint_tens  = tcc_pkg::bcd_tens(setpoint_in);
      result.setpoint_units = tcc_pkg::bcd_units(setpoint_in);
      result.run_timed_out  = timed_out;
   end

   `TCC_ASSERT_ALWAYS(a_lockout_count_in_lock, clock, reset, (lockout_left_ff != 24'd0) == is_lock)
   `TCC_ASSERT_IMPLY(a_run_count_in_run, clock, reset, run_left_ff != 16'd0, is_run)
   `TCC_ASSERT_NEXT(a_timeout_stops_run, clock, reset, fire && timed_out, !is_run)

endmodule

`default_nettype wire
